### rtl/tpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 6;
    localparam int NIB_W    = 4;
    localparam int ID_W     = 64;
    localparam int TRACE_W  = 2 * ID_W;
    localparam int VER_W    = 8;

    // Header layout positions
    localparam logic [POS_W-1:0] POS_MAX     = 6'd63;
    localparam logic [POS_W-1:0] DASH_A      = 6'd2;
    localparam logic [POS_W-1:0] DASH_B      = 6'd35;
    localparam logic [POS_W-1:0] DASH_C      = 6'd52;
    localparam logic [POS_W-1:0] DASH_EXT    = 6'd55;
    localparam logic [POS_W-1:0] FLAGS_LOW   = 6'd54;
    localparam logic [POS_W-1:0] LAST_MIN    = 6'd54;

    localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A_LOW  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_F_LOW  = 8'h66;
    localparam logic [VER_W-1:0]  VERSION_BAD = 8'hFF;

    // Classification of one header character
    typedef struct packed {
        logic             is_hex;
        logic             is_dash;
        logic [NIB_W-1:0] nibble;
    } char_class_t;

endpackage

`default_nettype wire

### rtl/tpp_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpp_char_if
    import tpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] header_char;
    logic              last_char;

    modport source (output valid, output header_char, output last_char, input ready);
    modport sink   (input valid, input header_char, input last_char, output ready);
endinterface

interface tpp_result_if
    import tpp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            header_valid;
    logic [ID_W-1:0] trace_id_high;
    logic [ID_W-1:0] trace_id_low;
    logic [ID_W-1:0] parent_span_id;
    logic            sampled_flag;

    modport source (output valid, output header_valid, output trace_id_high,
                    output trace_id_low, output parent_span_id, output sampled_flag,
                    input ready);
    modport sink   (input valid, input header_valid, input trace_id_high,
                    input trace_id_low, input parent_span_id, input sampled_flag,
                    output ready);
endinterface

`default_nettype wire

### rtl/tpp_char_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module tpp_char_decode
    import tpp_pkg::*;
(
    input  wire logic [CHAR_W-1:0] header_char,
    output char_class_t            char_class
);

    logic is_digit;
    logic is_lower;

    // Classify lowercase hex digits and the dash
    assign is_digit = (header_char >= CHAR_ZERO) && (header_char <= CHAR_NINE);
    assign is_lower = (header_char >= CHAR_A_LOW) && (header_char <= CHAR_F_LOW);

    always_comb
    begin
        char_class.is_hex  = is_digit || is_lower;
        char_class.is_dash = (header_char == CHAR_DASH);
        char_class.nibble  = '0;
        if (is_digit)
        begin
            char_class.nibble = header_char[NIB_W-1:0];
        end
        else if (is_lower)
        begin
            // 'a'..'f' carry 1..6 in the low bits; add nine for 10..15
            char_class.nibble = header_char[NIB_W-1:0] + 4'd9;
        end
    end

endmodule

`default_nettype wire

### rtl/traceparent_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Transaction
// hdr      sink     one header character, last_char marks the end of the header
// res      source   one parse result per header, given on its last character
//
// One character per cycle sustained while results are taken. A character is
// registered at the input, then decoded and folded into the parser state once the
// result side can advance; the last character loads the result register and clears
// the state for the next header.
// rst_n clears the parser state and both valid flags asynchronously.
// A stalled result holds the input register; the input stays open while the
// result register can drain in the same cycle.

module traceparent_header_parser_unit
    import tpp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tpp_char_if.sink    hdr,
    tpp_result_if.source res
);

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // Parser state
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [VER_W-1:0]   ver_reg,    ver_next;
    logic [TRACE_W-1:0] trace_reg,  trace_next;
    logic [ID_W-1:0]    parent_reg, parent_next;
    logic [NIB_W-1:0]   flags_reg,  flags_next;
    logic               tnz_reg,    tnz_next;
    logic               pnz_reg,    pnz_next;
    logic               err_reg,    err_next;

    // Result register
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [TRACE_W-1:0] out_trace_reg;
    logic [ID_W-1:0]    out_parent_reg;
    logic               out_sampled_reg;

    logic        advance;
    logic        step;
    logic        finish;
    logic        dash_pos;
    logic        header_ok;
    char_class_t char_class;

    assign advance   = !out_valid_reg || res.ready;
    assign hdr.ready = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign finish    = step && in_last_reg;

    tpp_char_decode u_decode
    (
        .header_char (in_char_reg),
        .char_class  (char_class)
    );

    // Fold the registered character into the parser state
    always_comb
    begin
        ver_next    = ver_reg;
        trace_next  = trace_reg;
        parent_next = parent_reg;
        flags_next  = flags_reg;
        tnz_next    = tnz_reg;
        pnz_next    = pnz_reg;
        err_next    = err_reg;
        dash_pos    = (pos_reg == DASH_A) || (pos_reg == DASH_B) ||
                      (pos_reg == DASH_C) || (pos_reg == DASH_EXT);

        if (dash_pos)
        begin
            if (!char_class.is_dash)
            begin
                err_next = 1'b1;
            end
        end
        else if (pos_reg < DASH_EXT)
        begin
            if (!char_class.is_hex)
            begin
                err_next = 1'b1;
            end
            else if (pos_reg < DASH_A)
            begin
                ver_next = {ver_reg[VER_W-NIB_W-1:0], char_class.nibble};
            end
            else if (pos_reg < DASH_B)
            begin
                trace_next = {trace_reg[TRACE_W-NIB_W-1:0], char_class.nibble};
                tnz_next   = tnz_reg || (char_class.nibble != '0);
            end
            else if (pos_reg < DASH_C)
            begin
                parent_next = {parent_reg[ID_W-NIB_W-1:0], char_class.nibble};
                pnz_next    = pnz_reg || (char_class.nibble != '0);
            end
            else if (pos_reg == FLAGS_LOW)
            begin
                flags_next = char_class.nibble;
            end
        end

        pos_next  = (pos_reg < POS_MAX) ? pos_reg + 6'd1 : pos_reg;
        header_ok = !err_next && (pos_reg >= LAST_MIN) && (ver_next != VERSION_BAD) &&
                    tnz_next && pnz_next;
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (hdr.ready)
        begin
            in_valid_reg <= hdr.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            in_char_reg <= hdr.header_char;
            in_last_reg <= hdr.last_char;
        end
    end

    // Advance parser state; clear it after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ver_reg    <= '0;
            trace_reg  <= '0;
            parent_reg <= '0;
            flags_reg  <= '0;
            tnz_reg    <= 1'b0;
            pnz_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (finish)
        begin
            pos_reg    <= '0;
            ver_reg    <= '0;
            trace_reg  <= '0;
            parent_reg <= '0;
            flags_reg  <= '0;
            tnz_reg    <= 1'b0;
            pnz_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            ver_reg    <= ver_next;
            trace_reg  <= trace_next;
            parent_reg <= parent_next;
            flags_reg  <= flags_next;
            tnz_reg    <= tnz_next;
            pnz_reg    <= pnz_next;
            err_reg    <= err_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && in_last_reg;
        end
    end

    // Result payload; zero the fields of a rejected header
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_ok_reg      <= header_ok;
            out_trace_reg   <= header_ok ? trace_next : '0;
            out_parent_reg  <= header_ok ? parent_next : '0;
            out_sampled_reg <= header_ok && flags_next[0];
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.header_valid   = out_ok_reg;
    assign res.trace_id_high  = out_trace_reg[TRACE_W-1:ID_W];
    assign res.trace_id_low   = out_trace_reg[ID_W-1:0];
    assign res.parent_span_id = out_parent_reg;
    assign res.sampled_flag   = out_sampled_reg;

    // A rejected header carries no id or flag
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.header_valid) |->
        (res.trace_id_high == '0 && res.trace_id_low == '0 &&
         res.parent_span_id == '0 && !res.sampled_flag))
        else $error("rejected header with nonzero fields");

    // An accepted header has both ids nonzero
    a_accept_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.header_valid) |->
        ((res.trace_id_high != '0 || res.trace_id_low != '0) && res.parent_span_id != '0))
        else $error("accepted header with an all-zero id");

    // The last character leaves a clean state for the next header
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (pos_reg == '0 && !err_reg && !tnz_reg && !pnz_reg && out_valid_reg))
        else $error("parser state not cleared after last character");

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tpp_pkg::*;

    localparam int           CYCLE_LIMIT  = 400000;
    localparam int           MAX_GAP      = 14;
    localparam int           TOTAL_CHARS  = 1900;
    localparam int           DRAIN_CYCLES = 8;
    localparam int           SHOWN_ERRORS = 10;
    localparam logic [7:0]   CHAR_A_UP    = 8'h41;
    localparam string        HEX_DIGITS   = "0123456789abcdef";

    typedef logic [CHAR_W-1:0] char_q_t[$];

    typedef struct {
        logic            header_valid;
        logic [ID_W-1:0] trace_id_high;
        logic [ID_W-1:0] trace_id_low;
        logic [ID_W-1:0] parent_span_id;
        logic            sampled_flag;
    } header_result_t;

    typedef enum {
        HDR_GOOD,
        HDR_LONG,
        HDR_SHORT,
        HDR_NOISE,
        HDR_UPPER,
        HDR_BAD_VERSION,
        HDR_ZERO_TRACE,
        HDR_ZERO_PARENT,
        HDR_BAD_EXT,
        HDR_TINY
    } header_kind_t;

    // Tracks the parse of the header in flight and the results still owed
    class header_checker;
        header_result_t   awaited[$];
        int               error_count;
        logic [POS_W-1:0] position;
        logic [VER_W-1:0] version;
        logic [ID_W-1:0]  trace_hi;
        logic [ID_W-1:0]  trace_lo;
        logic [ID_W-1:0]  parent;
        logic [NIB_W-1:0] flags_nib;
        logic             trace_nz;
        logic             parent_nz;
        logic             bad_format;

        function new();
            error_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            position   = '0;
            version    = '0;
            trace_hi   = '0;
            trace_lo   = '0;
            parent     = '0;
            flags_nib  = '0;
            trace_nz   = 1'b0;
            parent_nz  = 1'b0;
            bad_format = 1'b0;
        endfunction

        // Fold one accepted character into the parse; owe a result on the last one
        function void absorb_char(logic [CHAR_W-1:0] c, logic last);
            logic [POS_W-1:0] p;
            logic             digit_ok;
            logic [NIB_W-1:0] nib;
            header_result_t   r;
            p        = position;
            digit_ok = 1'b0;
            nib      = '0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                digit_ok = 1'b1;
                nib      = NIB_W'(c - CHAR_ZERO);
            end
            else if (c >= CHAR_A_LOW && c <= CHAR_F_LOW)
            begin
                digit_ok = 1'b1;
                nib      = NIB_W'(c - CHAR_A_LOW + 8'd10);
            end

            if (p == DASH_A || p == DASH_B || p == DASH_C || p == DASH_EXT)
            begin
                if (c != CHAR_DASH)
                    bad_format = 1'b1;
            end
            else if (p < DASH_EXT)
            begin
                if (!digit_ok)
                begin
                    bad_format = 1'b1;
                end
                else if (p < DASH_A)
                begin
                    version = {version[VER_W-NIB_W-1:0], nib};
                end
                else if (p < DASH_B)
                begin
                    {trace_hi, trace_lo} = {trace_hi[ID_W-NIB_W-1:0], trace_lo, nib};
                    if (nib != '0)
                        trace_nz = 1'b1;
                end
                else if (p < DASH_C)
                begin
                    parent = {parent[ID_W-NIB_W-1:0], nib};
                    if (nib != '0)
                        parent_nz = 1'b1;
                end
                else if (p == FLAGS_LOW)
                begin
                    flags_nib = nib;
                end
            end

            if (!last)
            begin
                if (position != POS_MAX)
                    position = position + POS_W'(1);
                return;
            end

            r.header_valid   = !bad_format && (p >= LAST_MIN) && version != VERSION_BAD
                               && trace_nz && parent_nz;
            r.trace_id_high  = r.header_valid ? trace_hi : '0;
            r.trace_id_low   = r.header_valid ? trace_lo : '0;
            r.parent_span_id = r.header_valid ? parent : '0;
            r.sampled_flag   = r.header_valid ? flags_nib[0] : 1'b0;
            awaited = {awaited, r};
            clear_state();
        endfunction

        function void report(string what, header_result_t e, header_result_t g);
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display({"%0t %s: exp v=%0b t=%h_%h p=%h s=%0b",
                          " | got v=%0b t=%h_%h p=%h s=%0b"},
                         $time, what,
                         e.header_valid, e.trace_id_high, e.trace_id_low,
                         e.parent_span_id, e.sampled_flag,
                         g.header_valid, g.trace_id_high, g.trace_id_low,
                         g.parent_span_id, g.sampled_flag);
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(header_result_t got);
            header_result_t e;
            if (awaited.size() == 0)
            begin
                e = '{default: 'x};
                report("unexpected result", e, got);
                return;
            end
            e = awaited.pop_front();
            if (e.header_valid !== got.header_valid
                || e.trace_id_high !== got.trace_id_high
                || e.trace_id_low !== got.trace_id_low
                || e.parent_span_id !== got.parent_span_id
                || e.sampled_flag !== got.sampled_flag)
                report("result mismatch", e, got);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int            cycle_count;
    int            sent_chars;
    bit            quiet_sender;
    bit            quiet_receiver;
    header_checker sb;

    tpp_char_if   hdr_ch ();
    tpp_result_if res_ch ();

    traceparent_header_parser_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [CHAR_W-1:0] hex_digit();
        return HEX_DIGITS[$urandom_range(0, 15)];
    endfunction

    function automatic char_q_t text_chars(string s);
        char_q_t q;
        q = {};
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        return q;
    endfunction

    function automatic header_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)      return HDR_GOOD;
        else if (r < 62) return HDR_LONG;
        else if (r < 68) return HDR_SHORT;
        else if (r < 74) return HDR_NOISE;
        else if (r < 79) return HDR_UPPER;
        else if (r < 84) return HDR_BAD_VERSION;
        else if (r < 88) return HDR_ZERO_TRACE;
        else if (r < 92) return HDR_ZERO_PARENT;
        else if (r < 96) return HDR_BAD_EXT;
        else             return HDR_TINY;
    endfunction

    // Build a well-formed header with random content, then extend or break it as asked
    function automatic char_q_t random_header(header_kind_t kind);
        char_q_t          q;
        int               cut;
        logic [CHAR_W-1:0] ext;
        do
        begin
            q = {};
            q = {q, hex_digit()};
            q = {q, hex_digit()};
        end while (q[0] == CHAR_F_LOW && q[1] == CHAR_F_LOW);
        q = {q, CHAR_DASH};
        repeat (32) q = {q, hex_digit()};
        q = {q, CHAR_DASH};
        repeat (16) q = {q, hex_digit()};
        q = {q, CHAR_DASH};
        repeat (2) q = {q, hex_digit()};

        case (kind)
            HDR_LONG:
            begin
                q = {q, CHAR_DASH};
                repeat ($urandom_range(1, 24)) q = {q, CHAR_W'($urandom_range(0, 255))};
            end
            HDR_BAD_EXT:
            begin
                do ext = CHAR_W'($urandom_range(0, 255)); while (ext == CHAR_DASH);
                q = {q, ext};
                repeat ($urandom_range(0, 8)) q = {q, CHAR_W'($urandom_range(0, 255))};
            end
            HDR_SHORT:
            begin
                cut = $urandom_range(1, int'(LAST_MIN));
                while (q.size() > cut) void'(q.pop_back());
            end
            HDR_NOISE:
                q[$urandom_range(0, int'(LAST_MIN))] = CHAR_W'($urandom_range(0, 255));
            HDR_UPPER:
                q[$urandom_range(int'(DASH_A) + 1, int'(DASH_B) - 1)] =
                    CHAR_A_UP + CHAR_W'($urandom_range(0, 5));
            HDR_BAD_VERSION:
            begin
                q[0] = CHAR_F_LOW;
                q[1] = CHAR_F_LOW;
            end
            HDR_ZERO_TRACE:
                for (int i = int'(DASH_A) + 1; i < int'(DASH_B); i++) q[i] = CHAR_ZERO;
            HDR_ZERO_PARENT:
                for (int i = int'(DASH_B) + 1; i < int'(DASH_C); i++) q[i] = CHAR_ZERO;
            HDR_TINY:
                q = {CHAR_W'($urandom_range(0, 255))};
            default:
                ;
        endcase
        return q;
    endfunction

    // Offer one character; entered and left at a falling edge
    task automatic send_char(logic [CHAR_W-1:0] c, logic last);
        int gap;
        gap = draw_gap(quiet_sender);
        if (gap > 0)
        begin
            hdr_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_ch.valid       = 1'b1;
        hdr_ch.header_char = c;
        hdr_ch.last_char   = last;
        do @(posedge clk); while (!hdr_ch.ready);
        sb.absorb_char(c, last);
        @(negedge clk);
    endtask

    task automatic send_header(char_q_t q);
        quiet_sender = ($urandom_range(0, 3) == 0);
        foreach (q[i])
            send_char(q[i], i == q.size() - 1);
        sent_chars += q.size();
    endtask

    // Hold off the sender until every owed result is back
    task automatic hold_until_drained();
        hdr_ch.valid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge clk);
    endtask

    // Accept results with random stalls
    task automatic collect_results();
        header_result_t got;
        int             gap;
        forever
        begin
            gap = draw_gap(quiet_receiver);
            if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.header_valid   = res_ch.header_valid;
            got.trace_id_high  = res_ch.trace_id_high;
            got.trace_id_low   = res_ch.trace_id_low;
            got.parent_span_id = res_ch.parent_span_id;
            got.sampled_flag   = res_ch.sampled_flag;
            sb.check_result(got);
            if ($urandom_range(0, 7) == 0)
                quiet_receiver = !quiet_receiver;
            @(negedge clk);
        end
    endtask

    initial
    begin
        string   directed[$];
        char_q_t q;

        sb                 = new();
        cycle_count        = 0;
        sent_chars         = 0;
        quiet_sender       = 1'b0;
        quiet_receiver     = 1'b0;
        rst_n              = 1'b0;
        hdr_ch.valid       = 1'b0;
        hdr_ch.header_char = '0;
        hdr_ch.last_char   = 1'b0;
        res_ch.ready       = 1'b0;

        // Hold reset, release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            collect_results();
        join_none

        // Directed headers: nominal, extremes, each rejection cause, length edges
        directed = {
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-00",
            "fe-ffffffffffffffffffffffffffffffff-ffffffffffffffff-ff",
            "00-00000000000000000000000000000001-0000000000000001-00",
            "ff-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
            "00-00000000000000000000000000000000-00f067aa0ba902b7-01",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-0000000000000000-01",
            "00-4BF92F3577B34DA6A3CE929D0E0E4736-00f067aa0ba902b7-01",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0",
            "0",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01-what-ever-comes-next-x",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01x",
            "00_4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-01",
            "00-4bf92f3577b34da6a3ce929d0e0e4736-00f067aa0ba902b7-0g"
        };
        foreach (directed[i])
            send_header(text_chars(directed[i]));

        // All-ones and all-zeros characters inside a header
        q     = text_chars(directed[0]);
        q[10] = 8'hFF;
        send_header(q);
        q     = text_chars(directed[0]);
        q     = {q, CHAR_DASH};
        q     = {q, 8'h00};
        send_header(q);

        hold_until_drained();

        // Random headers, mostly well formed
        while (sent_chars < TOTAL_CHARS)
        begin
            send_header(random_header(pick_kind()));
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        // Drain and settle
        hdr_ch.valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0 && sb.awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
